>>> sv/blifo_pkg.sv
package blifo_pkg;

    localparam int DEPTH = 16;
    localparam int WORD_W = 32;
    localparam int CAP_W = 5;
    localparam int POS_W = 5;
    localparam int OP_W = 3;
    localparam int LVL_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (LVL_W > CAP_W) ? LVL_W : CAP_W;
    localparam int IN_W = 40;
    localparam int OUT_W = 40;
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
    localparam logic [OP_W-1:0] OP_POP = 3'd1;
    localparam logic [OP_W-1:0] OP_PEEK = 3'd2;
    localparam logic [OP_W-1:0] OP_TOP = 3'd3;
    localparam logic [OP_W-1:0] OP_BOTTOM = 3'd4;

    typedef enum logic [1:0] {
        ST_OK = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_BADPOS = 2'd3
    } status_t;

    typedef struct packed {
        logic push;
        logic pop;
    } cell_ctrl_t;

endpackage

>>> sv/blifo_cell.sv
module blifo_cell (
    input  logic                         clk,
    input  blifo_pkg::cell_ctrl_t        ctrl,
    input  logic [blifo_pkg::WORD_W-1:0] above,
    input  logic [blifo_pkg::WORD_W-1:0] below,
    output logic [blifo_pkg::WORD_W-1:0] q
);

    logic [blifo_pkg::WORD_W-1:0] word_reg;
    logic [blifo_pkg::WORD_W-1:0] word_next;

    always_comb
    begin
        word_next = word_reg;
        if (ctrl.push)
        begin
            word_next = above;
        end
        else if (ctrl.pop)
        begin
            word_next = below;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign q = word_reg;

endmodule

>>> sv/bounded_lifo_stack_core.sv
// Channel   Direction  Payload (lowest bit up)
// s_*       in         op[2:0], value[34:3], position[39:35]
// m_*       out        data[31:0], status[33:32], is_empty[34], is_full[35], zero pad
// cfg_*     in         capacity[4:0]
//
// A new beat is accepted each cycle while the output register is empty
// or being drained, so the rate is one request per cycle.
// The stack is a row of word cells, cell 0 holding the top, that shift as a unit.
// Reset clears the level and sets the capacity to 16; cell contents are not reset.
// A stalled output holds its beat and stops further requests from being accepted.
module bounded_lifo_stack_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [blifo_pkg::IN_W-1:0]    s_tdata,  // op, value, position
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [blifo_pkg::OUT_W-1:0]   m_tdata,  // data, status, is_empty, is_full
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [blifo_pkg::CAP_W-1:0]   cfg_data  // capacity
);

    localparam int W = blifo_pkg::WORD_W;
    localparam int CW = blifo_pkg::CMP_W;
    localparam int D = blifo_pkg::DEPTH;

    logic [blifo_pkg::OP_W-1:0]  op;
    logic [W-1:0]                value;
    logic [blifo_pkg::POS_W-1:0] position;

    logic [blifo_pkg::LVL_W-1:0] level_reg;
    logic [blifo_pkg::LVL_W-1:0] level_next;
    logic [blifo_pkg::CAP_W-1:0] cap_reg;
    logic                        out_valid_reg;
    logic [blifo_pkg::OUT_W-1:0] out_data_reg;
    logic [blifo_pkg::OUT_W-1:0] out_data_next;

    logic [W-1:0]       cell_q [D];
    logic [W-1:0]       cell_above [D];
    logic [W-1:0]       cell_below [D];
    blifo_pkg::cell_ctrl_t ctrl;

    logic                accept;
    logic [CW-1:0]       level_ext;
    logic [CW-1:0]       cap_eff;
    logic [CW-1:0]       pos_ext;
    logic [CW-1:0]       peek_k;
    logic [CW-1:0]       bottom_k;
    logic [W-1:0]        peek_word;
    logic [W-1:0]        bottom_word;
    logic [W-1:0]        data;
    blifo_pkg::status_t  status;

    assign op = s_tdata[2:0];
    assign value = s_tdata[34:3];
    assign position = s_tdata[39:35];

    assign s_tready = !out_valid_reg || m_tready;
    assign accept = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign level_ext = CW'(level_reg);
    assign pos_ext = CW'(position);
    assign peek_k = pos_ext - CW'(1);
    assign bottom_k = level_ext - CW'(1);

    always_comb
    begin
        if (CW'(cap_reg) > CW'(D))
        begin
            cap_eff = CW'(D);
        end
        else
        begin
            cap_eff = CW'(cap_reg);
        end
    end

    always_comb
    begin
        peek_word = '0;
        bottom_word = '0;
        for (int k = 0; k < D; k++)
        begin
            if (peek_k == CW'(k))
            begin
                peek_word = cell_q[k];
            end
            if (bottom_k == CW'(k))
            begin
                bottom_word = cell_q[k];
            end
        end
    end

    always_comb
    begin
        data = '0;
        status = blifo_pkg::ST_OK;
        ctrl = '0;
        level_next = level_reg;
        case (op)
            blifo_pkg::OP_PUSH:
            begin
                if (level_ext >= cap_eff)
                begin
                    status = blifo_pkg::ST_OVERFLOW;
                end
                else
                begin
                    ctrl.push = 1'b1;
                    level_next = level_reg + 1'b1;
                end
            end
            blifo_pkg::OP_POP:
            begin
                if (level_reg == '0)
                begin
                    status = blifo_pkg::ST_UNDERFLOW;
                end
                else
                begin
                    ctrl.pop = 1'b1;
                    data = cell_q[0];
                    level_next = level_reg - 1'b1;
                end
            end
            blifo_pkg::OP_PEEK:
            begin
                if (position == '0 || pos_ext > level_ext)
                begin
                    status = blifo_pkg::ST_BADPOS;
                end
                else
                begin
                    data = peek_word;
                end
            end
            blifo_pkg::OP_TOP:
            begin
                if (level_reg == '0)
                begin
                    status = blifo_pkg::ST_UNDERFLOW;
                end
                else
                begin
                    data = cell_q[0];
                end
            end
            blifo_pkg::OP_BOTTOM:
            begin
                if (level_reg == '0)
                begin
                    status = blifo_pkg::ST_UNDERFLOW;
                end
                else
                begin
                    data = bottom_word;
                end
            end
            default:
            begin
                data = '0;
            end
        endcase
        if (!accept)
        begin
            ctrl = '0;
            level_next = level_reg;
        end
    end

    always_comb
    begin
        out_data_next = '0;
        out_data_next[31:0] = data;
        out_data_next[33:32] = status;
        out_data_next[34] = (level_next == '0);
        out_data_next[35] = (CW'(level_next) >= cap_eff);
    end

    genvar g;
    generate
        for (g = 0; g < D; g++)
        begin : g_cell
            if (g == 0)
            begin : g_top
                assign cell_above[g] = value;
            end
            else
            begin : g_mid
                assign cell_above[g] = cell_q[g-1];
            end
            if (g == D - 1)
            begin : g_last
                assign cell_below[g] = '0;
            end
            else
            begin : g_inner
                assign cell_below[g] = cell_q[g+1];
            end
            blifo_cell u_cell (
                .clk   (clk),
                .ctrl  (ctrl),
                .above (cell_above[g]),
                .below (cell_below[g]),
                .q     (cell_q[g])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
            cap_reg <= blifo_pkg::CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            level_reg <= level_next;
            if (cfg_valid)
            begin
                cap_reg <= cfg_data;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_data_reg;

endmodule

>>> tb/bounded_lifo_stack_core_test.sv
module bounded_lifo_stack_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [blifo_pkg::WORD_W-1:0] data;
        blifo_pkg::status_t           status;
        logic                         is_empty;
        logic                         is_full;
    } stack_result_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [blifo_pkg::IN_W-1:0]    s_tdata = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [blifo_pkg::OUT_W-1:0]   m_tdata;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [blifo_pkg::CAP_W-1:0]   cfg_data = '0;

    logic [blifo_pkg::WORD_W-1:0]  stack_words [blifo_pkg::DEPTH];
    int                            stack_level = 0;
    logic [blifo_pkg::CAP_W-1:0]   stack_capacity = blifo_pkg::CAP_RESET;

    stack_result_t     pending_results [$];
    stack_result_t     seen_result;
    stack_result_t     want_result;

    int                sender_idle_pct = 0;
    int                receiver_stall_pct = 0;
    int                failures = 0;
    int                requests_sent = 0;
    int                results_checked = 0;
    int                capacity_writes = 0;
    int                status_seen [4] = '{0, 0, 0, 0};
    int                cycle_count = 0;

    bounded_lifo_stack_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("bounded_lifo_stack_core: mismatch");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    function automatic stack_result_t predict_response(
        input logic [blifo_pkg::OP_W-1:0]   op,
        input logic [blifo_pkg::WORD_W-1:0] value,
        input logic [blifo_pkg::POS_W-1:0]  position);
        stack_result_t r;
        int            eff_cap;
        eff_cap = (stack_capacity > blifo_pkg::DEPTH) ? blifo_pkg::DEPTH
                                                      : int'(stack_capacity);
        r.data = '0;
        r.status = blifo_pkg::ST_OK;
        case (op)
            blifo_pkg::OP_PUSH:
            begin
                if (stack_level >= eff_cap)
                    r.status = blifo_pkg::ST_OVERFLOW;
                else
                begin
                    stack_words[stack_level] = value;
                    stack_level++;
                end
            end
            blifo_pkg::OP_POP:
            begin
                if (stack_level == 0)
                    r.status = blifo_pkg::ST_UNDERFLOW;
                else
                begin
                    stack_level--;
                    r.data = stack_words[stack_level];
                end
            end
            blifo_pkg::OP_PEEK:
            begin
                if (position == 0 || position > stack_level)
                    r.status = blifo_pkg::ST_BADPOS;
                else
                    r.data = stack_words[stack_level - position];
            end
            blifo_pkg::OP_TOP:
            begin
                if (stack_level == 0)
                    r.status = blifo_pkg::ST_UNDERFLOW;
                else
                    r.data = stack_words[stack_level - 1];
            end
            blifo_pkg::OP_BOTTOM:
            begin
                if (stack_level == 0)
                    r.status = blifo_pkg::ST_UNDERFLOW;
                else
                    r.data = stack_words[0];
            end
            default:
            begin
            end
        endcase
        r.is_empty = (stack_level == 0);
        r.is_full = (stack_level >= eff_cap);
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            seen_result.data = m_tdata[31:0];
            seen_result.status = blifo_pkg::status_t'(m_tdata[33:32]);
            seen_result.is_empty = m_tdata[34];
            seen_result.is_full = m_tdata[35];
            if (pending_results.size() == 0)
            begin
                $error("unexpected result beat: data %0h status %0d", seen_result.data,
                       seen_result.status);
                failures++;
            end
            else
            begin
                want_result = pending_results.pop_front();
                results_checked++;
                status_seen[seen_result.status]++;
                if (seen_result.data !== want_result.data)
                begin
                    $error("data: expected %0h, got %0h", want_result.data, seen_result.data);
                    failures++;
                end
                if (seen_result.status !== want_result.status)
                begin
                    $error("status: expected %0d, got %0d", want_result.status,
                           seen_result.status);
                    failures++;
                end
                if (seen_result.is_empty !== want_result.is_empty)
                begin
                    $error("is_empty: expected %0b, got %0b", want_result.is_empty,
                           seen_result.is_empty);
                    failures++;
                end
                if (seen_result.is_full !== want_result.is_full)
                begin
                    $error("is_full: expected %0b, got %0b", want_result.is_full,
                           seen_result.is_full);
                    failures++;
                end
            end
        end
    end

    task automatic send_request(input logic [blifo_pkg::OP_W-1:0]   op,
                                input logic [blifo_pkg::WORD_W-1:0] value,
                                input logic [blifo_pkg::POS_W-1:0]  position);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {position, value, op};
        do
            @(posedge clk);
        while (!s_tready);
        pending_results.push_back(predict_response(op, value, position));
        requests_sent++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [blifo_pkg::CAP_W-1:0] capacity);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data <= capacity;
        do
            @(posedge clk);
        while (!cfg_ready);
        stack_capacity = capacity;
        capacity_writes++;
        cfg_valid <= 1'b0;
    endtask

    task automatic test_empty_stack();
        send_request(blifo_pkg::OP_POP, 32'h1234_5678, 5'd1);
        send_request(blifo_pkg::OP_TOP, 32'h0, 5'd0);
        send_request(blifo_pkg::OP_BOTTOM, 32'h0, 5'd0);
        send_request(blifo_pkg::OP_PEEK, 32'h0, 5'd0);
        send_request(3'd5, 32'h0, 5'd1);
        send_request(3'd7, 32'hFFFF_FFFF, 5'd31);
    endtask

    task automatic test_push_peek_extremes();
        send_request(blifo_pkg::OP_PUSH, 32'h8000_0000, 5'd0);
        send_request(blifo_pkg::OP_PUSH, 32'h7FFF_FFFF, 5'd31);
        send_request(blifo_pkg::OP_PUSH, 32'hFFFF_FFFF, 5'd16);
        send_request(blifo_pkg::OP_PEEK, 32'h0, 5'd1);
        send_request(blifo_pkg::OP_PEEK, 32'h0, 5'd3);
        send_request(blifo_pkg::OP_PEEK, 32'h0, 5'd0);
        send_request(blifo_pkg::OP_PEEK, 32'h0, 5'd4);
        send_request(blifo_pkg::OP_PEEK, 32'hFFFF_FFFF, 5'd31);
        send_request(blifo_pkg::OP_TOP, 32'h0, 5'd0);
        send_request(blifo_pkg::OP_BOTTOM, 32'h0, 5'd0);
        send_request(3'd6, 32'h5A5A_5A5A, 5'd2);
    endtask

    task automatic test_capacity_below_level();
        write_capacity(5'd2);
        send_request(blifo_pkg::OP_PUSH, 32'h0000_0001, 5'd0);
        send_request(blifo_pkg::OP_POP, 32'h0, 5'd0);
        send_request(blifo_pkg::OP_POP, 32'h0, 5'd0);
        send_request(blifo_pkg::OP_PUSH, 32'h0000_0000, 5'd0);
    endtask

    task automatic test_zero_capacity();
        write_capacity(5'd0);
        send_request(blifo_pkg::OP_PUSH, 32'hDEAD_BEEF, 5'd0);
        send_request(blifo_pkg::OP_POP, 32'h0, 5'd0);
        send_request(blifo_pkg::OP_POP, 32'h0, 5'd0);
        send_request(blifo_pkg::OP_PUSH, 32'h0BAD_F00D, 5'd0);
    endtask

    task automatic test_random_traffic(input logic [blifo_pkg::CAP_W-1:0] capacity,
                                       input int count, input int mode);
        int                           n;
        int                           push_pct;
        int                           pick;
        logic [blifo_pkg::OP_W-1:0]   op;
        logic [blifo_pkg::WORD_W-1:0] value;
        logic [blifo_pkg::POS_W-1:0]  position;
        write_capacity(capacity);
        case (mode)
            1:
            begin
                sender_idle_pct = 51;
                receiver_stall_pct = 0;
            end
            2:
            begin
                sender_idle_pct = 0;
                receiver_stall_pct = 51;
            end
            3:
            begin
                sender_idle_pct = 10;
                receiver_stall_pct = 10;
            end
            default:
            begin
                sender_idle_pct = 0;
                receiver_stall_pct = 0;
            end
        endcase
        push_pct = 50;
        for (n = 0; n < count; n++)
        begin
            if ($urandom_range(31) == 0)
                push_pct = 25 * $urandom_range(1, 3);
            if ($urandom_range(99) < push_pct)
                op = blifo_pkg::OP_PUSH;
            else
            begin
                pick = $urandom_range(99);
                if (pick < 40)
                    op = blifo_pkg::OP_POP;
                else if (pick < 65)
                    op = blifo_pkg::OP_PEEK;
                else if (pick < 78)
                    op = blifo_pkg::OP_TOP;
                else if (pick < 91)
                    op = blifo_pkg::OP_BOTTOM;
                else
                    op = blifo_pkg::OP_W'($urandom_range(5, 7));
            end
            case ($urandom_range(7))
                0: value = 32'h8000_0000;
                1: value = 32'h7FFF_FFFF;
                default: value = $urandom;
            endcase
            if ($urandom_range(3) == 0)
                position = blifo_pkg::POS_W'($urandom_range(31));
            else
                position = blifo_pkg::POS_W'($urandom_range(0, stack_level + 1));
            send_request(op, value, position);
            if ($urandom_range(99) == 0)
                wait_drained();
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_stack();
        test_push_peek_extremes();
        test_capacity_below_level();
        test_zero_capacity();
        test_random_traffic(5'd16, 200, 0);
        test_random_traffic(5'd1, 200, 1);
        test_random_traffic(5'd31, 200, 2);
        test_random_traffic(5'd5, 200, 3);
        test_random_traffic(5'd0, 100, 0);
        test_random_traffic(5'd9, 200, 1);
        test_random_traffic(5'd16, 250, 2);
        test_random_traffic(5'd3, 200, 3);
        test_random_traffic(5'd12, 50, 0);
        wait_drained();
        repeat (12) @(posedge clk);
        $display("Sent %0d requests under %0d capacity settings and checked %0d results.",
                 requests_sent, capacity_writes, results_checked);
        $display("Results by status: ok %0d, overflow %0d, underflow %0d, bad position %0d.",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        if (failures == 0)
            $display("bounded_lifo_stack_core: match");
        else
            $display("bounded_lifo_stack_core: mismatch");
        $finish;
    end

endmodule
